// ===== design/vcr_pkg.sv =====
// Package for the vote confidence record: payload structs, request and
// state codes, hash constants and the popcount helper. No dependencies.
`default_nettype none

package vcr_pkg;

   localparam int HASH_W     = 16;
   localparam int CONF_W     = 15;
   localparam int INFLIGHT_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
   localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
   localparam logic [63:0] FIB_MUL = 64'd11400714819323198485;

   localparam logic [3:0]          AGREE_MIN = 4'd6;
   localparam logic [CONF_W-1:0]   CONF_MAX  = 15'h7fff;

   localparam logic [CONF_W-1:0]     SCORE_RESET        = 15'd128;
   localparam logic [INFLIGHT_W-1:0] MAX_INFLIGHT_RESET = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_SCORE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INFLIGHT = 2'd2;

   typedef enum logic [1:0] {
      REQ_VOTE    = 2'd0,
      REQ_POLL    = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_INIT    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic signed [63:0] node_id;
      logic               anonymous;
      logic [31:0]        vote_error;
      logic [7:0]         release_count;
      logic               init_accepted;
   } req_payload_type;

   typedef struct packed {
      logic                  changed;
      logic                  duplicate;
      logic                  accepted;
      logic [CONF_W-1:0]     confidence;
      logic                  finalized;
      logic                  poll_granted;
      logic [INFLIGHT_W-1:0] inflight;
   } rsp_payload_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== design/vcr_hash.sv =====
// Voter hash unit: LCG step plus Fibonacci hash, built from two 32x32
// multipliers over three partial-product steps. Uses vcr_pkg.
`default_nettype none

module vcr_hash (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [63:0]                lcg_operand,
   input  wire logic [63:0]                fib_operand,
   output logic                            done,
   output logic [vcr_pkg::HASH_W-1:0]      hash
);

   localparam logic [2:0] LAST_STEP = 3'd4;

   logic                         busy_ff;
   logic [2:0]                   step_ff;
   logic                         done_ff;
   logic                         upper_ff;
   logic [63:0]                  prod1_ff;
   logic [63:0]                  prod2_ff;
   logic [63:0]                  acc1_ff;
   logic [63:0]                  acc2_ff;
   logic [vcr_pkg::HASH_W-1:0]   hash_ff;

   logic [31:0] op_a1;
   logic [31:0] op_b1;
   logic [31:0] op_a2;
   logic [31:0] op_b2;
   logic [63:0] term1;
   logic [63:0] term2;
   logic [63:0] sum;

   // mod 2^64 product: lo*lo, plus (lo*hi + hi*lo) shifted up 32
   always_comb begin
      op_a1 = (step_ff == 3'd2) ? lcg_operand[63:32] : lcg_operand[31:0];
      op_a2 = (step_ff == 3'd2) ? fib_operand[63:32] : fib_operand[31:0];
      op_b1 = (step_ff == 3'd1) ? vcr_pkg::LCG_MUL[63:32] : vcr_pkg::LCG_MUL[31:0];
      op_b2 = (step_ff == 3'd1) ? vcr_pkg::FIB_MUL[63:32] : vcr_pkg::FIB_MUL[31:0];
      term1 = upper_ff ? {prod1_ff[31:0], 32'd0} : prod1_ff;
      term2 = upper_ff ? {prod2_ff[31:0], 32'd0} : prod2_ff;
      sum   = acc1_ff + acc2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc1_ff <= vcr_pkg::LCG_ADD;
         acc2_ff <= 64'd0;
      end else if (busy_ff) begin
         if (step_ff <= 3'd2) begin
            prod1_ff <= op_a1 * op_b1;
            prod2_ff <= op_a2 * op_b2;
            upper_ff <= (step_ff != 3'd0);
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd3) begin
            acc1_ff <= acc1_ff + term1;
            acc2_ff <= acc2_ff + term2;
         end
         if (step_ff == LAST_STEP) begin
            hash_ff <= sum[63:64-vcr_pkg::HASH_W];
         end
      end
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule

`default_nettype wire

// ===== design/vcr_cell.sv =====
// One quorum filter cell: holds a voter hash, compares it with the probe
// and passes its hash to the next cell on insert. Uses vcr_pkg.
`default_nettype none

module vcr_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire logic                       shift,
   input  wire logic [vcr_pkg::HASH_W-1:0] data_in,
   input  wire logic [vcr_pkg::HASH_W-1:0] probe,
   output logic [vcr_pkg::HASH_W-1:0]      data_out,
   output logic                            hit
);

   logic [vcr_pkg::HASH_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         data_ff <= '0;
      end else if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;
   assign hit      = (data_ff == probe);

endmodule

`default_nettype wire

// ===== design/vcr_top_doc_placeholder.sv =====
// Filter chain: a row of vcr_cell instances, newest hash at the head.
// Depends on vcr_pkg and vcr_cell.
`default_nettype none

module vcr_filter #(
   parameter int FILTER_DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire logic                       insert,
   input  wire logic [vcr_pkg::HASH_W-1:0] probe,
   output logic                            seen
);

   // only FILTER_DEPTH-1 cells are built and every one is compared, so
   // only the most recent FILTER_DEPTH-1 hashes are kept
   localparam int CELL_COUNT = FILTER_DEPTH - 1;

   logic [vcr_pkg::HASH_W-1:0] link [CELL_COUNT+1];
   logic [CELL_COUNT-1:0]      hits;

   assign link[0] = probe;

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      vcr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .shift    (insert),
         .data_in  (link[k]),
         .probe    (probe),
         .data_out (link[k+1]),
         .hit      (hits[k])
      );
   end

   assign seen = |hits;

endmodule

`default_nettype wire

// ===== design/vote_confidence_record.sv =====
// Vote confidence record. A poll, release, init or anonymous vote goes from
// the request register straight to the update state; a named vote first
// passes the hash unit's three 32x32 partial-product steps and the filter
// compare. One item at a time: a new item is taken only in the idle state.
// Reset (synchronous) clears histories, confidence, filter and in-flight
// count and loads hash_seed 0, finalization_score 128, max_inflight 10.
`default_nettype none

module vote_confidence_record #(
   parameter int FILTER_DEPTH = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire vcr_pkg::req_payload_type           req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output vcr_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                               csr_write,
   input  wire logic [vcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [vcr_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW = vcr_pkg::CONF_W;
   localparam int IW = vcr_pkg::INFLIGHT_W;

   // configuration
   logic [63:0]   hash_seed_ff;
   logic [CW-1:0] final_score_ff;
   logic [IW-1:0] max_inflight_ff;

   // record state
   vcr_pkg::state_type state_ff, state_in;
   vcr_pkg::req_payload_type item_ff;
   logic [7:0]    yes_hist_ff,  yes_hist_in;
   logic [7:0]    cons_hist_ff, cons_hist_in;
   logic          accepted_ff,  accepted_in;
   logic [CW-1:0] conf_ff,      conf_in;
   logic [IW-1:0] inflight_ff,  inflight_in;
   logic          seen_ff;
   logic          rsp_valid_ff;
   vcr_pkg::rsp_payload_type rsp_ff, rsp_in;

   // control
   logic req_take;
   logic can_load;
   logic hash_start;
   logic match_capture;
   logic update_fire;
   logic hash_done;
   logic [vcr_pkg::HASH_W-1:0] hash;
   logic seen;
   logic filter_clear;
   logic filter_insert;

   // vote evaluation
   logic       is_vote;
   logic       named_vote;
   logic       dup;
   logic       vote_y;
   logic       vote_c;
   logic [7:0] yes_next;
   logic [7:0] cons_next;
   logic       round_yes;
   logic       round_no;
   logic       changed;
   logic       granted;

   assign req_take   = req_valid && !req_stall;
   assign can_load   = !rsp_valid_ff || !rsp_stall;
   assign is_vote    = (item_ff.req_type == vcr_pkg::REQ_VOTE);
   assign named_vote = is_vote && !item_ff.anonymous;
   assign dup        = named_vote && seen_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vcr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_payload.req_type == vcr_pkg::REQ_VOTE && !req_payload.anonymous) begin
                  state_in = vcr_pkg::ST_HASH;
               end else begin
                  state_in = vcr_pkg::ST_UPDATE;
               end
            end
         end
         vcr_pkg::ST_HASH: begin
            if (hash_done) begin
               state_in = vcr_pkg::ST_MATCH;
            end
         end
         vcr_pkg::ST_MATCH: begin
            state_in = vcr_pkg::ST_UPDATE;
         end
         vcr_pkg::ST_UPDATE: begin
            if (can_load) begin
               state_in = vcr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vcr_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall     = 1'b1;
      hash_start    = 1'b0;
      match_capture = 1'b0;
      update_fire   = 1'b0;
      unique case (state_ff)
         vcr_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            hash_start = req_valid && req_payload.req_type == vcr_pkg::REQ_VOTE
                         && !req_payload.anonymous;
         end
         vcr_pkg::ST_HASH: begin
         end
         vcr_pkg::ST_MATCH: begin
            match_capture = 1'b1;
         end
         vcr_pkg::ST_UPDATE: begin
            update_fire = can_load;
         end
         default: begin
         end
      endcase
   end

   // the id is latched with the item; the hash unit reads it from the cycle after start
   vcr_hash u_hash (
      .clock       (clock),
      .reset       (reset),
      .start       (hash_start),
      .lcg_operand (item_ff.node_id),
      .fib_operand (item_ff.node_id ^ hash_seed_ff),
      .done        (hash_done),
      .hash        (hash)
   );

   assign filter_clear  = update_fire && item_ff.req_type == vcr_pkg::REQ_INIT;
   assign filter_insert = update_fire && named_vote && !seen_ff;

   vcr_filter #(
      .FILTER_DEPTH (FILTER_DEPTH)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .clear  (filter_clear),
      .insert (filter_insert),
      .probe  (hash),
      .seen   (seen)
   );

   // record update
   always_comb begin
      vote_y    = (item_ff.vote_error == 32'd0);
      vote_c    = !item_ff.vote_error[31];
      yes_next  = {yes_hist_ff[6:0], vote_y};
      cons_next = {cons_hist_ff[6:0], vote_c};
      round_yes = vcr_pkg::popcount8(yes_next & cons_next) > vcr_pkg::AGREE_MIN;
      round_no  = vcr_pkg::popcount8(~yes_next & cons_next) > vcr_pkg::AGREE_MIN;

      yes_hist_in  = yes_hist_ff;
      cons_hist_in = cons_hist_ff;
      accepted_in  = accepted_ff;
      conf_in      = conf_ff;
      inflight_in  = inflight_ff;
      changed      = 1'b0;
      granted      = 1'b0;

      case (item_ff.req_type)
         vcr_pkg::REQ_VOTE: begin
            inflight_in = (inflight_ff != '0) ? inflight_ff - IW'(1) : '0;
            if (!dup) begin
               yes_hist_in  = yes_next;
               cons_hist_in = cons_next;
               if (round_yes || round_no) begin
                  if (accepted_ff == round_yes) begin
                     if (conf_ff != vcr_pkg::CONF_MAX) begin
                        conf_in = conf_ff + CW'(1);
                        changed = (conf_in == final_score_ff);
                     end
                  end else begin
                     accepted_in = round_yes;
                     conf_in     = '0;
                     changed     = 1'b1;
                  end
               end
            end
         end
         vcr_pkg::REQ_POLL: begin
            if (inflight_ff < max_inflight_ff) begin
               inflight_in = inflight_ff + IW'(1);
               granted     = 1'b1;
            end
         end
         vcr_pkg::REQ_RELEASE: begin
            inflight_in = (inflight_ff > item_ff.release_count)
                          ? inflight_ff - item_ff.release_count : '0;
         end
         default: begin
            yes_hist_in  = '0;
            cons_hist_in = '0;
            accepted_in  = item_ff.init_accepted;
            conf_in      = '0;
            inflight_in  = '0;
         end
      endcase

      rsp_in.changed      = changed;
      rsp_in.duplicate    = dup;
      rsp_in.accepted     = accepted_in;
      rsp_in.confidence   = conf_in;
      rsp_in.finalized    = (conf_in >= final_score_ff);
      rsp_in.poll_granted = granted;
      rsp_in.inflight     = inflight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= vcr_pkg::ST_IDLE;
         hash_seed_ff    <= 64'd0;
         final_score_ff  <= vcr_pkg::SCORE_RESET;
         max_inflight_ff <= vcr_pkg::MAX_INFLIGHT_RESET;
         yes_hist_ff     <= '0;
         cons_hist_ff    <= '0;
         accepted_ff     <= 1'b0;
         conf_ff         <= '0;
         inflight_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               vcr_pkg::CSR_HASH_SEED:    hash_seed_ff    <= csr_data;
               vcr_pkg::CSR_FINAL_SCORE:  final_score_ff  <= csr_data[CW-1:0];
               vcr_pkg::CSR_MAX_INFLIGHT: max_inflight_ff <= csr_data[IW-1:0];
               default: begin
               end
            endcase
         end
         if (update_fire) begin
            yes_hist_ff  <= yes_hist_in;
            cons_hist_ff <= cons_hist_in;
            accepted_ff  <= accepted_in;
            conf_ff      <= conf_in;
            inflight_ff  <= inflight_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            // drop the result once its transfer is done
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_payload;
      end
      if (match_capture) begin
         seen_ff <= seen;
      end
      if (update_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
